@@ design/mf3x3_pkg.sv @@
// shared types, constants and sorting-network functions of the 3x3 median filter
package mf3x3_pkg;

  localparam int PIX_W      = 8;
  localparam int CFG_W_BITS = 11;
  localparam int CFG_H_BITS = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int ROW_W      = CFG_H_BITS + 1;

  localparam logic [CFG_W_BITS-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [CFG_H_BITS-1:0] HEIGHT_RESET = 16'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_index_t;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [8:0][PIX_W-1:0] pix9_t;
  typedef logic [3:0] slot_t;

  // which window borders fall outside the frame
  typedef struct packed {
    logic top;
    logic bot;
    logic left;
    logic right;
  } border_t;

  // compare-exchange: smaller value to slot a, larger to slot b
  function automatic pix9_t cx(pix9_t p, slot_t a, slot_t b);
    pix9_t r;
    r = p;
    if (p[a] > p[b]) begin
      r[a] = p[b];
      r[b] = p[a];
    end
    return r;
  endfunction

  // first half of the nine-input median network: sort each triple
  function automatic pix9_t sort_triples(pix9_t v);
    pix9_t p;
    p = v;
    p = cx(p, 4'd1, 4'd2);
    p = cx(p, 4'd4, 4'd5);
    p = cx(p, 4'd7, 4'd8);
    p = cx(p, 4'd0, 4'd1);
    p = cx(p, 4'd3, 4'd4);
    p = cx(p, 4'd6, 4'd7);
    p = cx(p, 4'd1, 4'd2);
    p = cx(p, 4'd4, 4'd5);
    p = cx(p, 4'd7, 4'd8);
    return p;
  endfunction

  // second half: merge the sorted triples down to the median
  function automatic pix_t median_finish(pix9_t v);
    pix9_t p;
    p = v;
    p = cx(p, 4'd0, 4'd3);
    p = cx(p, 4'd5, 4'd8);
    p = cx(p, 4'd4, 4'd7);
    p = cx(p, 4'd3, 4'd6);
    p = cx(p, 4'd1, 4'd4);
    p = cx(p, 4'd2, 4'd5);
    p = cx(p, 4'd4, 4'd7);
    p = cx(p, 4'd4, 4'd2);
    p = cx(p, 4'd6, 4'd4);
    p = cx(p, 4'd4, 4'd2);
    return p[4];
  endfunction

endpackage

@@ design/median_filter_3x3_core.sv @@
// 3x3 median filter over a raster-order 8-bit gray pixel stream
//
// Takes one pixel per transaction in raster order and returns the median of the
// zero-padded 3x3 neighbourhood of each frame position. Outputs lag the input by
// one row plus one pixel; after the last pixel of a frame, send clamped width+1 pad
// transactions (tuser high) to drain the remaining outputs. Pad transactions that
// arrive before the frame's last pixel are dropped; pixel transactions after it
// act as pads. The last output of a frame carries tlast. Rate: one transaction
// per clock unless the output stalls; three register stages (line-store read,
// window and first sort half, median merge) are loaded in turn, and the median
// that a transaction completes sits in the output register until it is taken.
// Each line store uses one read and one write port per clock. Write the
// configuration registers only between frames; width is clamped to 1..MAX_WIDTH
// and a zero height is taken as 1. Line stores need no clearing after reset.
module median_filter_3x3_core
  import mf3x3_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // pixel input
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [PIX_W-1:0]      s_axis_tdata,   // [7:0] pixel_value
  input  logic                  s_axis_tuser,   // [0] is_pad
  // median output
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [PIX_W-1:0]      m_axis_tdata,   // [7:0] median_value
  output logic                  m_axis_tlast    // frame_last
);

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int EW_MIN = $clog2(MAX_WIDTH + 1);
  localparam int EW     = (EW_MIN > CFG_W_BITS) ? EW_MIN : CFG_W_BITS;

  // configuration registers
  logic [CFG_W_BITS-1:0] image_width;
  logic [CFG_H_BITS-1:0] image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data[CFG_W_BITS-1:0];
        CFG_IMAGE_HEIGHT: image_height <= cfg_data[CFG_H_BITS-1:0];
      endcase
    end
  end

  // effective frame size after clamping
  logic [EW-1:0]         eff_w, eff_w_m1;
  logic [CFG_H_BITS-1:0] eff_h, eff_h_m1;

  always_comb begin
    if (image_width == '0) begin
      eff_w = EW'(1);
    end else if (EW'(image_width) > EW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(image_width);
    end
    eff_h    = (image_height == '0) ? CFG_H_BITS'(1) : image_height;
    eff_w_m1 = eff_w - EW'(1);
    eff_h_m1 = eff_h - CFG_H_BITS'(1);
  end

  // input and output position counters
  logic [CW-1:0]         in_column, in_column_next;
  logic [ROW_W-1:0]      in_row, in_row_next;
  logic [CW-1:0]         out_col, out_col_next;
  logic [CFG_H_BITS-1:0] out_row, out_row_next;

  // pipeline handshake
  logic adv_o, adv2, adv1;
  logic accept;

  // stage 1: line-store read data and item info
  logic          v1;
  pix_t          pix1;
  logic [CW-1:0] col1;
  logic          emit1;
  border_t       brd1;
  logic          last1;
  logic          fwd1;
  pix_t          fwd_val1;
  pix_t          rd_up, rd_mid;

  // stage 2: partly sorted neighbourhood
  logic  v2;
  pix9_t sorted2;
  logic  last2;

  // output register
  logic  ov;
  pix_t  omed;
  logic  olast;

  assign adv_o         = !ov || m_axis_tready;
  assign adv2          = !v2 || adv_o;
  assign adv1          = !v1 || adv2;
  assign s_axis_tready = adv1;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // input decode
  logic    draining, drop, flush, counted, emit, col_wrap, last;
  pix_t    pix_in;
  border_t brd;

  always_comb begin
    draining = in_row >= ROW_W'(eff_h);
    drop     = !draining && s_axis_tuser;
    // nothing pending past the frame end: restart the counters
    flush    = draining && (out_row >= eff_h);
    counted  = accept && !drop && !flush;
    pix_in   = draining ? '0 : s_axis_tdata;
    // first output once the stream is a row plus a pixel ahead
    emit     = (in_row >= ROW_W'(2)) || ((in_row == ROW_W'(1)) && (in_column != '0));
    col_wrap = EW'(in_column) >= eff_w_m1;

    brd.top   = out_row == '0;
    brd.bot   = out_row >= eff_h_m1;
    brd.left  = out_col == '0;
    brd.right = EW'(out_col) >= eff_w_m1;
    last      = (brd.bot && brd.right) || (out_row >= eff_h);
  end

  always_comb begin
    in_column_next = in_column;
    in_row_next    = in_row;
    out_col_next   = out_col;
    out_row_next   = out_row;
    if (accept && flush) begin
      in_column_next = '0;
      in_row_next    = '0;
      out_col_next   = '0;
      out_row_next   = '0;
    end else if (counted) begin
      if (col_wrap) begin
        in_column_next = '0;
        in_row_next    = in_row + ROW_W'(1);
      end else begin
        in_column_next = in_column + CW'(1);
      end
      if (emit) begin
        if (last) begin
          in_column_next = '0;
          in_row_next    = '0;
          out_col_next   = '0;
          out_row_next   = '0;
        end else if (brd.right) begin
          out_col_next = '0;
          out_row_next = out_row + CFG_H_BITS'(1);
        end else begin
          out_col_next = out_col + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column <= '0;
      in_row    <= '0;
      out_col   <= '0;
      out_row   <= '0;
    end else begin
      in_column <= in_column_next;
      in_row    <= in_row_next;
      out_col   <= out_col_next;
      out_row   <= out_row_next;
    end
  end

  // line stores: middle takes the new pixel at once, upper takes the old
  // middle value when the item leaves stage 1
  pix_t line_store_upper  [MAX_WIDTH];
  pix_t line_store_middle [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (counted) begin
      rd_up                        <= line_store_upper[in_column];
      rd_mid                       <= line_store_middle[in_column];
      line_store_middle[in_column] <= pix_in;
    end
    if (v1 && adv2) begin
      line_store_upper[col1] <= rd_mid;
    end
  end

  // stage 1 registers; same-column read while the upper write is in flight
  // takes the value being written
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv1) begin
      v1 <= counted;
    end
  end

  always_ff @(posedge clk) begin
    if (counted) begin
      pix1     <= pix_in;
      col1     <= in_column;
      emit1    <= emit;
      brd1     <= brd;
      last1    <= last;
      fwd1     <= v1 && adv2 && (col1 == in_column);
      fwd_val1 <= rd_mid;
    end
  end

  // window shift and border masking
  logic [2:0][2:0][PIX_W-1:0] window_regs, window_next;
  pix_t  up_eff;
  pix9_t nb;

  always_comb begin
    up_eff = fwd1 ? fwd_val1 : rd_up;
    for (int j = 0; j < 3; j++) begin
      window_next[j][0] = window_regs[j][1];
      window_next[j][1] = window_regs[j][2];
    end
    window_next[0][2] = up_eff;
    window_next[1][2] = rd_mid;
    window_next[2][2] = pix1;
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        if ((k == 0 && brd1.left) || (k == 2 && brd1.right) ||
            (j == 0 && brd1.top) || (j == 2 && brd1.bot)) begin
          nb[j*3+k] = '0;
        end else begin
          nb[j*3+k] = window_next[j][k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_regs <= '0;
    end else if (v1 && adv2) begin
      window_regs <= window_next;
    end
  end

  // stage 2
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv2) begin
      v2 <= v1 && emit1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && v1 && emit1) begin
      sorted2 <= sort_triples(nb);
      last2   <= last1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (adv_o) begin
      ov <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_o && v2) begin
      omed  <= median_finish(sorted2);
      olast <= last2;
    end
  end

  assign m_axis_tvalid = ov;
  assign m_axis_tdata  = omed;
  assign m_axis_tlast  = olast;

endmodule

@@ dv/median_check.sv @@
// checker that predicts the 3x3 median stream and compares every output transaction
`timescale 1ns / 1ps

module median_check
  import mf3x3_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [PIX_W-1:0]      in_pixel,
  input  logic                  in_pad,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [PIX_W-1:0]      out_median,
  input  logic                  out_last,
  output int                    fails,
  output int                    pending
);

  typedef struct packed {
    pix_t median;
    logic last;
  } median_result_t;

  typedef logic [8:0][PIX_W-1:0] nine_pix_t;

  median_result_t median_q[$];

  // predicted block state
  pix_t                  upper_row  [MAX_WIDTH];
  pix_t                  middle_row [MAX_WIDTH];
  pix_t                  win        [3][3];
  logic [CFG_W_BITS-1:0] width_reg;
  logic [CFG_H_BITS-1:0] height_reg;
  int unsigned           col;
  int unsigned           row;
  int unsigned           out_pos;
  int unsigned           out_seen;

  function automatic pix_t median_of(nine_pix_t v);
    nine_pix_t s;
    pix_t      t;
    s = v;
    for (int i = 0; i < 8; i++) begin
      for (int j = 0; j < 8 - i; j++) begin
        if (s[j] > s[j+1]) begin
          t      = s[j];
          s[j]   = s[j+1];
          s[j+1] = t;
        end
      end
    end
    return s[4];
  endfunction

  task automatic report_mismatch(input string what);
    $display("median_check: output %0d: %s", out_seen, what);
    fails++;
  endtask

  // one accepted input transaction: shift the window, maybe predict one median
  task automatic filter_step(input pix_t pix_in, input logic pad);
    int unsigned    w;
    int unsigned    h;
    int unsigned    total;
    int unsigned    v;
    int unsigned    r;
    int unsigned    c;
    logic           draining;
    logic           outside;
    pix_t           pix;
    pix_t           up;
    pix_t           mid;
    nine_pix_t      nb;
    median_result_t res;
    w        = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
    h        = (height_reg == 0) ? 1 : height_reg;
    total    = w * h;
    v        = row * w + col;
    draining = (v >= total);
    if (draining || !pad) begin
      if (draining && out_pos >= total) begin
        col     = 0;
        row     = 0;
        out_pos = 0;
      end else begin
        pix             = draining ? '0 : pix_in;
        up              = upper_row[col];
        mid             = middle_row[col];
        upper_row[col]  = mid;
        middle_row[col] = pix;
        for (int j = 0; j < 3; j++) begin
          win[j][0] = win[j][1];
          win[j][1] = win[j][2];
        end
        win[0][2] = up;
        win[1][2] = mid;
        win[2][2] = pix;
        col++;
        if (col >= w) begin
          col = 0;
          row++;
        end
        if (v >= w + 1) begin
          r = out_pos / w;
          c = out_pos % w;
          for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
              outside = (k == 0 && c == 0) || (k == 2 && c == w - 1) ||
                        (j == 0 && r == 0) || (j == 2 && r >= h - 1);
              nb[j*3+k] = outside ? '0 : win[j][k];
            end
          end
          res.median = median_of(nb);
          res.last   = (out_pos + 1 >= total);
          median_q.push_back(res);
          out_pos++;
          if (res.last) begin
            col     = 0;
            row     = 0;
            out_pos = 0;
          end
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      median_q.delete();
      for (int i = 0; i < MAX_WIDTH; i++) begin
        upper_row[i]  = '0;
        middle_row[i] = '0;
      end
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) win[j][k] = '0;
      end
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      col        = 0;
      row        = 0;
      out_pos    = 0;
      out_seen   = 0;
      fails      = 0;
    end else begin
      if (out_valid === 1'b1 && out_ready === 1'b1) begin
        if (median_q.size() == 0) begin
          report_mismatch("output transaction with no prediction pending");
        end else begin
          median_result_t res;
          res = median_q.pop_front();
          if (out_median !== res.median)
            report_mismatch($sformatf("median %0d, predicted %0d", out_median, res.median));
          if (out_last !== res.last)
            report_mismatch($sformatf("tlast %b, predicted %b", out_last, res.last));
        end
        out_seen++;
      end
      if (in_valid === 1'b1 && in_ready === 1'b1) filter_step(in_pixel, in_pad);
      if (cfg_we === 1'b1) begin
        case (cfg_index)
          CFG_IMAGE_WIDTH:  width_reg  = cfg_data[CFG_W_BITS-1:0];
          CFG_IMAGE_HEIGHT: height_reg = cfg_data[CFG_H_BITS-1:0];
          default: ;
        endcase
      end
    end
    pending <= median_q.size();
  end

endmodule

@@ dv/tb_median_filter_3x3_core.sv @@
// stimulus and verdict for the 3x3 median filter core, checked by median_check
`timescale 1ns / 1ps

module tb_median_filter_3x3_core;
  import mf3x3_pkg::*;

  localparam int MAX_W          = 1024;
  localparam int CYCLE_LIMIT    = 1000000;
  localparam int SETTLE_CYCLES  = 8;     // lets the pipeline registers empty
  localparam int RX_HOLD_CYCLES = 300;

  // how the pixel values of a frame are drawn
  typedef enum {
    PIX_FULL,
    PIX_EXTREME,
    PIX_NARROW
  } pix_mode_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [PIX_W-1:0]      s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [PIX_W-1:0]      m_axis_tdata;
  logic                  m_axis_tlast;

  int   fails;
  int   pending;
  int   cycle_count = 0;
  int   item_count  = 0;
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  int   rx_hold_req = 0;

  // effective frame size the block is currently set to
  int unsigned cur_w = 640;
  int unsigned cur_h = 480;

  median_filter_3x3_core #(
    .MAX_WIDTH (MAX_W)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] pixel_value
    .s_axis_tuser  (s_axis_tuser),   // [0] is_pad
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [7:0] median_value
    .m_axis_tlast  (m_axis_tlast)    // frame_last
  );

  median_check #(
    .MAX_WIDTH (MAX_W)
  ) i_median_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_pixel   (s_axis_tdata),
    .in_pad     (s_axis_tuser),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_median (m_axis_tdata),
    .out_last   (m_axis_tlast),
    .fails      (fails),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit, far above the slowest correct run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[median_filter_3x3_core] ERROR");
      $finish;
    end
  end

  // receiver side: random back-pressure, plus a long hold-off on request
  initial begin
    int hold_seen;
    hold_seen     = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req != hold_seen) begin
        hold_seen = rx_hold_req;
        m_axis_tready <= 1'b0;
        for (int n = 0; n < RX_HOLD_CYCLES; n++) @(negedge clk);
      end
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // called and returns at a falling edge; valid is left high after the transaction
  task automatic send_item(input logic [PIX_W-1:0] pix, input logic pad);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tuser  <= pad;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // hold the sender until every predicted median has come out, then settle
  task automatic wait_idle();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    for (int n = 0; n < SETTLE_CYCLES; n++) @(posedge clk);
    @(negedge clk);
  endtask

  // both size registers back to back; junk above bit 10 of the width write
  task automatic write_size(input logic [CFG_W_BITS-1:0] w_reg,
                            input logic [CFG_H_BITS-1:0] h_reg);
    logic [CFG_DATA_W-CFG_W_BITS-1:0] junk;
    junk      = (CFG_DATA_W-CFG_W_BITS)'($urandom_range(2**(CFG_DATA_W-CFG_W_BITS) - 1));
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IMAGE_WIDTH;
    cfg_data  <= {junk, w_reg};
    @(negedge clk);
    cfg_index <= CFG_IMAGE_HEIGHT;
    cfg_data  <= h_reg;
    @(negedge clk);
    cfg_we    <= 1'b0;
    // same clamping the block applies
    cur_w = (w_reg == 0) ? 1 : ((w_reg > MAX_W) ? MAX_W : w_reg);
    cur_h = (h_reg == 0) ? 1 : h_reg;
  endtask

  // one whole frame plus its drain; optionally resized first while idle
  task automatic run_frame(input logic [CFG_W_BITS-1:0] w_reg,
                           input logic [CFG_H_BITS-1:0] h_reg,
                           input pix_mode_t mode, input logic new_size);
    logic [PIX_W-1:0] px;
    int unsigned      n_px;
    if (new_size) begin
      s_axis_tvalid <= 1'b0;
      wait_idle();
      write_size(w_reg, h_reg);
    end
    n_px = cur_w * cur_h;
    for (int unsigned i = 0; i < n_px; i++) begin
      // stray pad inside the frame, the block drops it
      if ($urandom_range(19) == 0) send_item(PIX_W'($urandom_range(255)), 1'b1);
      case (mode)
        PIX_EXTREME: px = $urandom_range(1) ? 8'hFF : 8'h00;
        PIX_NARROW:  px = PIX_W'($urandom_range(103, 100));
        default:     px = PIX_W'($urandom_range(255));
      endcase
      send_item(px, 1'b0);
    end
    // drain: real pads mostly, some pixels that act as pads
    for (int unsigned i = 0; i <= cur_w; i++)
      send_item(PIX_W'($urandom_range(255)), $urandom_range(3) != 0);
    item_count += n_px + cur_w + 1;
  endtask

  // mostly tiny frames, a few wider ones, some zero sizes, some kept sizes
  task automatic random_frames(input int n_items);
    int                    target;
    logic [CFG_W_BITS-1:0] w_reg;
    logic [CFG_H_BITS-1:0] h_reg;
    target = item_count + n_items;
    while (item_count < target) begin
      case ($urandom_range(9))
        0:       w_reg = '0;
        1:       w_reg = CFG_W_BITS'($urandom_range(24, 9));
        default: w_reg = CFG_W_BITS'($urandom_range(6, 1));
      endcase
      h_reg = ($urandom_range(9) == 0) ? '0 : CFG_H_BITS'($urandom_range(5, 1));
      run_frame(w_reg, h_reg, pix_mode_t'($urandom_range(2)), $urandom_range(2) != 0);
    end
  endtask

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = CFG_IMAGE_WIDTH;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    for (int n = 0; n < 11; n++) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // sender nearly always busy, receiver mostly stalled
    tx_idle_pct = 6;
    rx_idle_pct = 85;

    // zero width and height act as a 1x1 frame; pad before the pixel is
    // dropped, a pixel after the last one drains like a pad
    write_size('0, '0);
    send_item(8'hA5, 1'b1);
    send_item(8'hFF, 1'b0);
    send_item(8'h3C, 1'b0);
    send_item(8'h00, 1'b1);
    item_count += 3;
    // black and white pixels on a 3x3 frame, then a short one-row frame
    run_frame(11'd3, 16'd3, PIX_EXTREME, 1'b1);
    run_frame(11'd4, 16'd1, PIX_FULL, 1'b1);

    random_frames(130);

    // sender mostly idle, receiver nearly always ready
    tx_idle_pct = 85;
    rx_idle_pct = 6;
    random_frames(130);

    // no idling from here on
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    s_axis_tvalid <= 1'b0;
    wait_idle();
    // long receiver hold-off while the sender keeps offering, block must stall
    @(posedge clk);
    rx_hold_req = rx_hold_req + 1;
    @(negedge clk);
    run_frame(11'd4, 16'd6, PIX_FULL, 1'b1);

    // zero width with a few rows: a single column
    run_frame(11'd0, 16'd3, PIX_EXTREME, 1'b1);

    random_frames(130);

    s_axis_tvalid <= 1'b0;
    wait_idle();
    if (fails == 0 && pending == 0) begin
      $display("[median_filter_3x3_core] OK");
    end else begin
      $display("[median_filter_3x3_core] ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/mf3x3_pkg.sv
design/median_filter_3x3_core.sv
dv/median_check.sv
dv/tb_median_filter_3x3_core.sv
